### hdl/assert_macros.svh
// Assertion macros used by the core design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, ignored while rst is high.
`define ASSERT_CLK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/ldk_pkg.sv
package ldk_pkg;

  localparam int RootBits = 35;
  localparam int RadW     = 2 * RootBits;
  localparam int RemW     = RootBits + 3;
  localparam int ArgW     = 38;
  localparam int LinW     = 36;

  typedef struct packed {
    logic                   valid;
    logic                   last;
    logic                   clamped;
    logic [47:0]            dt;
    logic [LinW-1:0]        lin;
  } side_t;

  typedef struct packed {
    side_t                  side;
    logic [RadW-1:0]        rad;
    logic [RemW-1:0]        rem;
    logic [RootBits-1:0]    root;
  } cell_t;

endpackage

### hdl/ldk_root_cell.sv
// One step of the digit-by-digit square root: takes the next two radicand
// bits, tries the subtraction and hands the partial root to the next cell.
module ldk_root_cell (
  input  logic          clk,
  input  logic          rst,
  input  ldk_pkg::cell_t din,
  output ldk_pkg::cell_t dout
);

  logic [ldk_pkg::RemW-1:0]     cand;
  logic [ldk_pkg::RemW-1:0]     trial;
  logic                         ge;

  always_comb begin
    cand  = {din.rem[ldk_pkg::RemW-3:0], din.rad[ldk_pkg::RadW-1 -: 2]};
    trial = ldk_pkg::RemW'({din.root, 2'b01});
    ge    = (cand >= trial);
  end

  always_ff @(posedge clk) begin
    dout.rad  <= din.rad << 2;
    dout.rem  <= ge ? (cand - trial) : cand;
    dout.root <= {din.root[ldk_pkg::RootBits-2:0], ge};
    if (rst) begin
      dout.side <= '0;
    end else begin
      dout.side <= din.side;
    end
  end

endmodule

### hdl/ldk_front.sv
// Front end: relative energy x, the linear term and the root argument.
module ldk_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [47:0]   time_offset,
  input  logic [31:0]   energy_offset,
  input  logic          last_particle,
  input  logic          drift_mode,
  input  logic [31:0]   beta_recip_sq,
  input  logic [39:0]   energy_recip,
  output ldk_pkg::cell_t cout
);

  // Stage 0: operand capture.
  logic        v0, last0, neg0;
  logic [47:0] dt0;
  logic [31:0] mag0;
  // Stage 1: partial products of |dE| * energy_recip.
  logic        v1, last1, neg1;
  logic [47:0] dt1;
  logic [51:0] pl1, ph1;
  // Stage 2: clamped x.
  logic        v2, last2, xneg2;
  logic [47:0] dt2;
  logic [31:0] xmag2;
  // Stage 3: ibs*|x| or x*x.
  logic        v3, last3, xneg3;
  logic [47:0] dt3;
  logic [31:0] xmag3;
  logic [63:0] prod3;
  // Stage 4: linear term and s = x^2 + 2x.
  logic        v4, last4, sneg4;
  logic [47:0] dt4;
  logic [ldk_pkg::LinW-1:0] lin4;
  logic [33:0] smag4;
  // Stage 5: ibs*|s|.
  logic        v5, last5, sneg5;
  logic [47:0] dt5;
  logic [ldk_pkg::LinW-1:0] lin5;
  logic [65:0] prod5;

  logic [71:0] full2;
  logic [37:0] q2, lim2;
  logic [31:0] opa3;
  logic [34:0] tmag4;
  logic [32:0] sq4;
  logic [35:0] x2, sx4, s4, sneg_val;
  logic [37:0] q6;
  logic [39:0] arg6;

  always_comb begin
    full2 = {20'b0, pl1} + {ph1, 20'b0};
    q2    = full2[71:34];
    lim2  = neg1 ? 38'h0080000000 : 38'h007fffffff;
    opa3  = drift_mode ? xmag2 : beta_recip_sq;
    tmag4 = prod3[62:28];
    sq4   = prod3[62:30];
    x2    = {3'b0, xmag3, 1'b0};
    sx4   = xneg3 ? (36'd0 - x2) : x2;
    s4    = {3'b0, sq4} + sx4;
    sneg_val = 36'd0 - s4;
    q6    = prod5[65:28];
    arg6  = (40'd1 << 30) + (sneg5 ? (40'd0 - {2'b0, q6}) : {2'b0, q6});
  end

  always_ff @(posedge clk) begin
    // Payload.
    dt0   <= time_offset;
    last0 <= last_particle;
    neg0  <= energy_offset[31];
    mag0  <= energy_offset[31] ? (~energy_offset + 32'd1) : energy_offset;

    dt1   <= dt0;
    last1 <= last0;
    neg1  <= neg0;
    pl1   <= mag0 * energy_recip[19:0];
    ph1   <= mag0 * energy_recip[39:20];

    dt2   <= dt1;
    last2 <= last1;
    xneg2 <= neg1;
    xmag2 <= (q2 > lim2) ? lim2[31:0] : q2[31:0];

    dt3   <= dt2;
    last3 <= last2;
    xneg3 <= xneg2;
    xmag3 <= xmag2;
    prod3 <= opa3 * xmag2;

    dt4   <= dt3;
    last4 <= last3;
    lin4  <= xneg3 ? (36'd0 - {1'b0, tmag4}) : {1'b0, tmag4};
    sneg4 <= s4[35];
    smag4 <= s4[35] ? sneg_val[33:0] : s4[33:0];

    dt5   <= dt4;
    last5 <= last4;
    lin5  <= lin4;
    sneg5 <= sneg4;
    prod5 <= beta_recip_sq * smag4;

    cout.side.dt      <= dt5;
    cout.side.last    <= last5;
    cout.side.lin     <= lin5;
    cout.side.clamped <= drift_mode & arg6[39];
    cout.rad  <= ldk_pkg::RadW'(arg6[39] ? 38'd0 : arg6[ldk_pkg::ArgW-1:0]) << 30;
    cout.rem  <= '0;
    cout.root <= '0;

    // Valid chain.
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      cout.side.valid <= 1'b0;
    end else begin
      v0 <= accept;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      cout.side.valid <= v5;
    end
  end

endmodule

### hdl/ldk_back.sv
// Back end: slip times the chosen delta, then the saturating add to dt.
module ldk_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          drift_mode,
  input  logic [47:0]   time_slip,
  input  ldk_pkg::cell_t cin,
  output logic          done,
  output logic [47:0]   new_time_offset,
  output logic          saturated,
  output logic          root_clamped,
  output logic          last_out
);

  localparam logic signed [55:0] DtMax = 56'sd140737488355327;
  localparam logic signed [55:0] DtMin = -56'sd140737488355328;

  logic        v1, last1, clamp1, neg1;
  logic [47:0] dt1, sm1;
  logic [34:0] vm1;
  logic        v2, last2, clamp2, neg2;
  logic [47:0] dt2;
  logic [41:0] p00, p10;
  logic [40:0] p01, p11;
  logic        v3, last3, clamp3;
  logic [47:0] dt3;
  logic [55:0] term3;

  logic [35:0] rv, vsel, vneg_val;
  logic [83:0] total;
  logic [53:0] tm;
  logic signed [55:0] nt;

  always_comb begin
    rv       = {1'b0, cin.root} - (36'd1 << 30);
    vsel     = drift_mode ? rv : cin.side.lin;
    vneg_val = 36'd0 - vsel;
    total    = 84'(p00) + (84'(p01) << 18) + (84'(p10) << 24) + (84'(p11) << 42);
    tm       = total[83:30];
    nt       = $signed({{8{dt3[47]}}, dt3}) + $signed(term3);
  end

  always_ff @(posedge clk) begin
    dt1    <= cin.side.dt;
    last1  <= cin.side.last;
    clamp1 <= cin.side.clamped;
    neg1   <= vsel[35] ^ time_slip[47];
    vm1    <= vsel[35] ? vneg_val[34:0] : vsel[34:0];
    sm1    <= time_slip[47] ? (48'd0 - time_slip) : time_slip;

    dt2    <= dt1;
    last2  <= last1;
    clamp2 <= clamp1;
    neg2   <= neg1;
    p00    <= sm1[23:0]  * vm1[17:0];
    p01    <= sm1[23:0]  * vm1[34:18];
    p10    <= sm1[47:24] * vm1[17:0];
    p11    <= sm1[47:24] * vm1[34:18];

    dt3    <= dt2;
    last3  <= last2;
    clamp3 <= clamp2;
    term3  <= neg2 ? (56'd0 - {2'b0, tm}) : {2'b0, tm};

    last_out     <= last3;
    root_clamped <= clamp3;
    priority if (nt > DtMax) begin
      new_time_offset <= DtMax[47:0];
      saturated       <= 1'b1;
    end else if (nt < DtMin) begin
      new_time_offset <= DtMin[47:0];
      saturated       <= 1'b1;
    end else begin
      new_time_offset <= nt[47:0];
      saturated       <= 1'b0;
    end

    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= cin.side.valid;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

endmodule

### hdl/longitudinal_drift_kick_core.sv
// Channel   Handshake           Payload
// input     start / busy        time_offset, energy_offset, last_particle
// result    done (strobe)       new_time_offset, saturated, root_clamped, last_out
// config    wr_en               wr_index, wr_data
//
// One particle is taken in every clock cycle outside reset; each result passes
// through the front-end stages, the 35 square-root cells in the middle of the
// chain and the multiply stages before and after them.
// Reset is synchronous: it clears all valid flags and restores the register
// defaults, and busy is high while rst is high. The receiver cannot stall, so
// busy is never raised outside reset.
module longitudinal_drift_kick_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [47:0] time_offset,
  input  logic signed [31:0] energy_offset,
  input  logic               last_particle,
  output logic               done,
  output logic signed [47:0] new_time_offset,
  output logic               saturated,
  output logic               root_clamped,
  output logic               last_out,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [47:0]        wr_data
);

  `include "assert_macros.svh"

  // Register indexes of the configuration port.
  localparam logic [1:0] RegDriftMode = 2'd0;
  localparam logic [1:0] RegTimeSlip  = 2'd1;
  localparam logic [1:0] RegInvBetaSq = 2'd2;
  localparam logic [1:0] RegInvEnergy = 2'd3;

  // Cycles from the edge that takes an item to the edge that takes its result.
  localparam int Latency = 46;

  logic        drift_mode;
  logic [47:0] time_slip;
  logic [31:0] beta_recip_sq;
  logic [39:0] energy_recip;

  logic        accept;
  logic [47:0] nto;

  ldk_pkg::cell_t chain [0:ldk_pkg::RootBits];

  // The pipeline never holds items back, so the only time it refuses one
  // is during reset.
  assign busy   = rst;
  assign accept = start & ~busy;
  assign new_time_offset = nto;

  // Configuration registers. Write only while no item is in flight; not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      drift_mode    <= 1'b1;
      time_slip     <= '0;
      beta_recip_sq <= 32'h10000000;
      energy_recip  <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        RegDriftMode: drift_mode    <= wr_data[0];
        RegTimeSlip:  time_slip     <= wr_data;
        RegInvBetaSq: beta_recip_sq <= wr_data[31:0];
        RegInvEnergy: energy_recip  <= wr_data[39:0];
      endcase
    end
  end

  // The front end forms x = dE/E, the linear term and the root argument,
  // and loads the first root cell.
  ldk_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .time_offset  (time_offset),
    .energy_offset(energy_offset),
    .last_particle(last_particle),
    .drift_mode   (drift_mode),
    .beta_recip_sq(beta_recip_sq),
    .energy_recip (energy_recip),
    .cout         (chain[0])
  );

  // Each cell resolves one bit of the root and passes the partial root,
  // remainder and particle sideband to its neighbor every cycle. Linear
  // mode items ride along and simply ignore the root.
  for (genvar i = 0; i < ldk_pkg::RootBits; i++) begin : g_cell
    ldk_root_cell u_cell (
      .clk (clk),
      .rst (rst),
      .din (chain[i]),
      .dout(chain[i+1])
    );
  end

  // The back end multiplies by the slip, adds the old offset and saturates.
  ldk_back u_back (
    .clk            (clk),
    .rst            (rst),
    .drift_mode     (drift_mode),
    .time_slip      (time_slip),
    .cin            (chain[ldk_pkg::RootBits]),
    .done           (done),
    .new_time_offset(nto),
    .saturated      (saturated),
    .root_clamped   (root_clamped),
    .last_out       (last_out)
  );

  // Every result comes from an item taken exactly one latency earlier.
  `ASSERT_CLK_RST(a_done_from_item, done |-> $past(accept, Latency), "result without item")
  // A clipped result sits at one end of the range.
  `ASSERT_CLK_RST(a_sat_at_limit,
    done && saturated |-> (nto == 48'h7fffffffffff || nto == 48'h800000000000),
    "saturated result not at a limit")
  // Only the exact mode can clamp the root argument.
  `ASSERT_CLK_RST(a_clamp_exact, done && root_clamped |-> drift_mode,
    "root clamp in linear mode")
  // Reset empties the pipeline at once.
  `ASSERT_CLK(a_reset_flush, rst |=> !done, "result right after reset")

endmodule

### tb/ldk_tb_pkg.sv
`timescale 1ns / 100ps

package ldk_tb_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_DRIFT_MODE   = 2'd0,
    REG_TIME_SLIP    = 2'd1,
    REG_BETA_RECIP   = 2'd2,
    REG_ENERGY_RECIP = 2'd3
  } ldk_reg_e;

  // Drift modes.
  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_EXACT  = 1'b1;

endpackage

### tb/ldk_drift_checker.sv
`timescale 1ns / 100ps

module ldk_drift_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [47:0] time_offset,
  input  logic signed [31:0] energy_offset,
  input  logic               last_particle,
  input  logic               done,
  input  logic signed [47:0] new_time_offset,
  input  logic               saturated,
  input  logic               root_clamped,
  input  logic               last_out,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [47:0]        wr_data,
  output int                 errors,
  output int                 pending
);

  typedef struct {
    logic signed [47:0] new_dt;
    logic               sat;
    logic               clamped;
    logic               last;
  } drift_result_t;

  localparam longint Q30_ONE = 64'sd1 << 30;
  localparam longint DT_MAX  = 64'sd140737488355327;
  localparam longint DT_MIN  = -64'sd140737488355328;

  logic               mode;
  logic signed [47:0] slip;
  logic [31:0]        ibs;
  logic [39:0]        inv_e;

  drift_result_t drift_due_q[$];

  // floor(a*b / 2^s), capped at the largest positive 64-bit value.
  function automatic logic [63:0] mul_floor(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> s;
    if (p > 128'h7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
    return p[63:0];
  endfunction

  // trunc(a*b / 2^s) in sign-magnitude.
  function automatic longint mul_trunc(longint a, longint b, int s);
    logic        neg;
    logic [63:0] ma, mb, r;
    neg = (a < 0) != (b < 0);
    ma  = a < 0 ? -a : a;
    mb  = b < 0 ? -b : b;
    r   = mul_floor(ma, mb, s);
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // floor(sqrt(a * 2^30)) by the restoring digit method.
  function automatic longint root_q30(logic [63:0] a);
    logic [127:0] rad, rem, root, trial;
    rad  = {64'd0, a} << 30;
    rem  = '0;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      rem   = (rem << 2) | rad[2*i +: 2];
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return longint'(root[63:0]);
  endfunction

  function automatic drift_result_t drift_predict(logic signed [47:0] dt,
                                                  logic signed [31:0] de,
                                                  logic last);
    drift_result_t res;
    longint x, term, nt, sq, s, arg;
    logic [63:0] ux;
    res.clamped = 1'b0;
    res.sat     = 1'b0;
    res.last    = last;
    x = mul_trunc(longint'(de), longint'({24'd0, inv_e}), 34);
    if (x > 64'sd2147483647) x = 64'sd2147483647;
    if (x < -64'sd2147483648) x = -64'sd2147483648;
    if (mode == ldk_tb_pkg::MODE_LINEAR) begin
      term = mul_trunc(longint'(slip), mul_trunc(longint'({32'd0, ibs}), x, 28), 30);
    end else begin
      ux  = x < 0 ? -x : x;
      sq  = longint'((ux * ux) >> 30);
      s   = sq + 2 * x;
      arg = Q30_ONE + mul_trunc(longint'({32'd0, ibs}), s, 28);
      if (arg < 0) begin
        arg = 0;
        res.clamped = 1'b1;
      end
      term = mul_trunc(longint'(slip), root_q30(arg) - Q30_ONE, 30);
    end
    nt = longint'(dt) + term;
    if (nt > DT_MAX) begin
      nt = DT_MAX;
      res.sat = 1'b1;
    end
    if (nt < DT_MIN) begin
      nt = DT_MIN;
      res.sat = 1'b1;
    end
    res.new_dt = nt[47:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    drift_result_t want;
    if (rst) begin
      mode  = ldk_tb_pkg::MODE_EXACT;
      slip  = '0;
      ibs   = 32'h1000_0000;
      inv_e = '0;
      drift_due_q.delete();
    end else begin
      if (wr_en) begin
        case (ldk_tb_pkg::ldk_reg_e'(wr_index))
          ldk_tb_pkg::REG_DRIFT_MODE:   mode  = wr_data[0];
          ldk_tb_pkg::REG_TIME_SLIP:    slip  = wr_data;
          ldk_tb_pkg::REG_BETA_RECIP:   ibs   = wr_data[31:0];
          ldk_tb_pkg::REG_ENERGY_RECIP: inv_e = wr_data[39:0];
          default: ;
        endcase
      end
      if (done) begin
        if (drift_due_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = drift_due_q.pop_front();
          if (new_time_offset !== want.new_dt)
            report_mismatch("new_time_offset", longint'(new_time_offset),
                            longint'(want.new_dt));
          if (saturated !== want.sat)
            report_mismatch("saturated", saturated, want.sat);
          if (root_clamped !== want.clamped)
            report_mismatch("root_clamped", root_clamped, want.clamped);
          if (last_out !== want.last)
            report_mismatch("last_out", last_out, want.last);
        end
      end
      if (start && !busy)
        drift_due_q.push_back(drift_predict(time_offset, energy_offset, last_particle));
    end
    pending <= drift_due_q.size();
  end

endmodule

### tb/longitudinal_drift_kick_core_test.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the drift core. The checker beside the block
// predicts every result and counts mismatches; this module only feeds items,
// rewrites the registers between phases and decides pass or fail.
module longitudinal_drift_kick_core_test;

  // Waits after a burst add a margin once every expected result is back.
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 220;

  localparam logic signed [47:0] DT_HI = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] DT_LO = 48'sh8000_0000_0000;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [47:0] time_offset;
  logic signed [31:0] energy_offset;
  logic               last_particle;
  logic               done;
  logic signed [47:0] new_time_offset;
  logic               saturated;
  logic               root_clamped;
  logic               last_out;
  logic               wr_en;
  logic [1:0]         wr_index;
  logic [47:0]        wr_data;
  int                 errors;
  int                 pending;
  int                 cycles;

  longitudinal_drift_kick_core dut (.*);

  ldk_drift_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A hung block must still end the run with a verdict.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL longitudinal_drift_kick_core");
      $finish;
    end
  end

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  // Signed values spread over all magnitudes, not only the huge ones.
  function automatic logic signed [47:0] rand_slip();
    return $signed(rand48()) >>> $urandom_range(0, 47);
  endfunction

  function automatic logic signed [31:0] rand_energy();
    return $signed($urandom) >>> $urandom_range(0, 31);
  endfunction

  function automatic logic [39:0] rand_inv_energy();
    logic [47:0] r;
    r = rand48();
    return r[39:0] >> $urandom_range(0, 39);
  endfunction

  function automatic logic [31:0] rand_ibs();
    case ($urandom_range(0, 3))
      0: return 32'h1000_0000 + ($urandom >> $urandom_range(4, 31));
      1: return $urandom >> $urandom_range(0, 31);
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [47:0] rand_dt();
    case ($urandom_range(0, 7))
      0: return DT_HI - ($urandom & 32'hFFFF);
      1: return DT_LO + ($urandom & 32'hFFFF);
      default: return rand48();
    endcase
  endfunction

  // Most gaps are zero or short; a few are long.
  function automatic int rand_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offers one item and holds it until the block takes it. The strobe is left
  // high so back-to-back items need no second assignment in one step.
  task automatic send_item(logic signed [47:0] dt, logic signed [31:0] de, logic last,
                           int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    time_offset   <= dt;
    energy_offset <= de;
    last_particle <= last;
    do @(posedge clk); while (busy);
  endtask

  // Ends the current burst and waits until every expected result is back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic mode, logic signed [47:0] slip, logic [31:0] ibs,
                           logic [39:0] inv_e);
    wr_en    <= 1'b1;
    wr_index <= ldk_tb_pkg::REG_DRIFT_MODE;
    wr_data  <= {47'd0, mode};
    @(posedge clk);
    wr_index <= ldk_tb_pkg::REG_TIME_SLIP;
    wr_data  <= slip;
    @(posedge clk);
    wr_index <= ldk_tb_pkg::REG_BETA_RECIP;
    wr_data  <= {16'd0, ibs};
    @(posedge clk);
    wr_index <= ldk_tb_pkg::REG_ENERGY_RECIP;
    wr_data  <= {8'd0, inv_e};
    @(posedge clk);
    wr_en    <= 1'b0;
  endtask

  // Directed items: field extremes, including energy values that drive x to
  // both saturation limits and time offsets at both ends of their range.
  task automatic directed_items();
    send_item(DT_HI, 32'sh7FFF_FFFF, 1'b0, 0);
    send_item(DT_LO, 32'sh8000_0000, 1'b1, 0);
    send_item(48'sd0, 32'sd0, 1'b0, 0);
    send_item(DT_HI, -32'sd1, 1'b1, 1);
    send_item(DT_LO, 32'sd1, 1'b0, 0);
    send_item(-48'sd1, 32'sh4000_0000, 1'b1, 0);
    send_item(48'sd1, -32'sh4000_0000, 1'b0, 2);
  endtask

  logic               p_mode;
  logic signed [47:0] p_slip;
  logic [31:0]        p_ibs;
  logic [39:0]        p_inv_e;

  initial begin
    cycles        = 0;
    rst           = 1'b1;
    start         = 1'b0;
    time_offset   = '0;
    energy_offset = '0;
    last_particle = 1'b0;
    wr_en         = 1'b0;
    wr_index      = ldk_tb_pkg::REG_DRIFT_MODE;
    wr_data       = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // First items run on the register defaults left by reset.
    directed_items();
    drain();

    // Large slip with a steep ibs, in the exact and then the linear mode: the
    // sum runs into both saturation limits.
    configure(ldk_tb_pkg::MODE_EXACT, DT_HI, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
    directed_items();
    drain();
    configure(ldk_tb_pkg::MODE_LINEAR, DT_LO, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
    directed_items();
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          p_mode = ldk_tb_pkg::MODE_LINEAR; p_slip = DT_LO; p_ibs = 32'h0;
          p_inv_e = 40'h0;
        end
        1: begin
          p_mode = ldk_tb_pkg::MODE_EXACT; p_slip = DT_LO; p_ibs = 32'hFFFF_FFFF;
          p_inv_e = rand_inv_energy();
        end
        2: begin
          p_mode = ldk_tb_pkg::MODE_EXACT; p_slip = DT_HI; p_ibs = 32'h1000_0000;
          p_inv_e = 40'hFF_FFFF_FFFF;
        end
        default: begin
          p_mode = 1'($urandom_range(0, 1)); p_slip = rand_slip(); p_ibs = rand_ibs();
          p_inv_e = rand_inv_energy();
        end
      endcase
      configure(p_mode, p_slip, p_ibs, p_inv_e);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Once per phase the feed stops until the pipe has fully emptied.
        if (i == PHASE_ITEMS / 2) begin
          start <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        // Some stretches run with no gaps at all.
        send_item(rand_dt(), rand_energy(), 1'($urandom_range(0, 1)),
                  (i % 64 < 16) ? 0 : rand_gap());
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASS longitudinal_drift_kick_core");
    end else begin
      $display("FAIL longitudinal_drift_kick_core");
    end
    $finish;
  end

endmodule
